/* hw/rtl/dll_pkg.sv */
// shared types, codes and constants of the doubly linked list manager
`timescale 1ns / 1ps

package dll_pkg;

  // default pool size
  localparam int POOL_NODES_DEF = 64;

  // fixed field widths
  localparam int OPCODE_W = 3;
  localparam int NODE_W   = 6;
  localparam int LINK7_W  = 7;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // input opcodes
  localparam logic [OPCODE_W-1:0] OP_PREPEND = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_BEFORE  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_AFTER   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd4;

  // classified command kinds
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_PREPEND = 3'd0;
  localparam kind_t KIND_APPEND  = 3'd1;
  localparam kind_t KIND_BEFORE  = 3'd2;
  localparam kind_t KIND_AFTER   = 3'd3;
  localparam kind_t KIND_REMOVE  = 3'd4;
  localparam kind_t KIND_HOLD    = 3'd5;
  localparam kind_t KIND_SKIP    = 3'd6;

  // input beat
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [NODE_W-1:0]   node_index;
    logic [LINK7_W-1:0]  ref_index;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [LINK7_W-1:0] head_index;
    logic [LINK7_W-1:0] tail_index;
    logic [LINK7_W-1:0] node_total;
    logic [LINK7_W-1:0] node_next;
    logic [LINK7_W-1:0] node_prev;
  } out_item_t;

  // classified command, ref_node is valid for before and after only
  typedef struct packed {
    kind_t              kind;
    logic [NODE_W-1:0]  node;
    logic [LINK7_W-1:0] ref_node;
  } cmd_t;

  // queue status toward back and top
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // back status
  typedef struct packed {
    logic idle;
    logic pop;
  } back_status_t;

endpackage

/* hw/rtl/dll_front.sv */
// front: accepts input beats and classifies them into commands
`timescale 1ns / 1ps

module dll_front #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF
) (
  input  logic              start,
  input  logic              busy,
  input  dll_pkg::in_item_t in_item,
  output logic              push,
  output dll_pkg::cmd_t     cmd
);

  logic node_ok;
  logic ref_ok;

  // range checks against the pool
  assign node_ok = 32'(in_item.node_index) < POOL_NODES;
  assign ref_ok  = 32'(in_item.ref_index) < POOL_NODES;

  assign push = start && !busy;

  // opcode decode, a missing reference swaps before/after for append/prepend
  always_comb begin
    cmd.node     = in_item.node_index;
    cmd.ref_node = in_item.ref_index;
    unique case (in_item.opcode)
      dll_pkg::OP_PREPEND: cmd.kind = dll_pkg::KIND_PREPEND;
      dll_pkg::OP_APPEND:  cmd.kind = dll_pkg::KIND_APPEND;
      dll_pkg::OP_BEFORE:  cmd.kind = ref_ok ? dll_pkg::KIND_BEFORE : dll_pkg::KIND_APPEND;
      dll_pkg::OP_AFTER:   cmd.kind = ref_ok ? dll_pkg::KIND_AFTER : dll_pkg::KIND_PREPEND;
      dll_pkg::OP_REMOVE:  cmd.kind = dll_pkg::KIND_REMOVE;
      default:             cmd.kind = dll_pkg::KIND_HOLD;
    endcase
    if (!node_ok) begin
      cmd.kind = dll_pkg::KIND_SKIP;
    end
  end

endmodule

/* hw/rtl/dll_queue.sv */
// short command queue between front and back
`timescale 1ns / 1ps

module dll_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dll_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output dll_pkg::cmd_t       pop_cmd,
  output dll_pkg::q_status_t  status
);

  localparam int DEPTH = dll_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dll_pkg::cmd_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign status.full  = count_r == CNT_W'(DEPTH);
  assign status.empty = count_r == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_cmd      = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= CNT_W'(count_r - 1'b1);
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/dll_back.sv */
// back: link memories, head/tail/count and the three-step sequencer
`timescale 1ns / 1ps

module dll_back #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dll_pkg::q_status_t    q_status,
  input  dll_pkg::cmd_t         cmd,
  output dll_pkg::back_status_t status,
  output logic                  out_strobe,
  output dll_pkg::out_item_t    out_item
);

  localparam int LINK_W = $clog2(POOL_NODES + 1);
  localparam int IDX_W  = $clog2(POOL_NODES);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_NODES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_W1   = 2'd1;
  localparam logic [1:0] S_W2   = 2'd2;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;

  logic [LINK_W-1:0] next_mem [POOL_NODES];
  logic [LINK_W-1:0] prev_mem [POOL_NODES];

  dll_pkg::kind_t    kind_r;
  logic [LINK_W-1:0] node_r;
  logic [LINK_W-1:0] ref_r;
  logic [LINK_W-1:0] rn_r;
  logic [LINK_W-1:0] rp_r;
  logic [LINK_W-1:0] head_r;
  logic [LINK_W-1:0] tail_r;
  logic [LINK_W-1:0] total_r;
  logic [LINK_W-1:0] head_nxt;
  logic [LINK_W-1:0] tail_nxt;
  logic [LINK_W-1:0] total_nxt;
  logic [LINK_W-1:0] nn;
  logic [LINK_W-1:0] np;
  logic              out_valid_r;
  dll_pkg::out_item_t out_item_r;

  logic              pop;
  logic [LINK_W-1:0] cmd_node;
  logic [LINK_W-1:0] cmd_ref;
  logic [LINK_W-1:0] rd_link;

  logic              nx_we;
  logic [LINK_W-1:0] nx_addr;
  logic [LINK_W-1:0] nx_data;
  logic              pv_we;
  logic [LINK_W-1:0] pv_addr;
  logic [LINK_W-1:0] pv_data;

  logic              head_ok;
  logic              tail_ok;
  logic              rn_ok;
  logic              rp_ok;
  logic [LINK_W-1:0] count_up;
  logic [LINK_W-1:0] count_down;

  assign pop          = (state_r == S_IDLE) && !q_status.empty;
  assign status.idle  = state_r == S_IDLE;
  assign status.pop   = pop;
  assign cmd_node     = LINK_W'(cmd.node);
  assign cmd_ref      = LINK_W'(cmd.ref_node);
  assign rd_link      = (cmd.kind == dll_pkg::KIND_BEFORE || cmd.kind == dll_pkg::KIND_AFTER)
                        ? cmd_ref : cmd_node;

  assign head_ok    = head_r < LINK_NONE;
  assign tail_ok    = tail_r < LINK_NONE;
  assign rn_ok      = rn_r < LINK_NONE;
  assign rp_ok      = rp_r < LINK_NONE;
  assign count_up   = (total_r != LINK_NONE) ? LINK_W'(total_r + 1'b1) : total_r;
  assign count_down = (total_r != '0) ? LINK_W'(total_r - 1'b1) : total_r;

  // sequencer: read, first writes, second writes and result
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = pop ? S_W1 : S_IDLE;
      S_W1:    state_nxt = S_W2;
      S_W2:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // link write selection, each memory takes at most one write per step in list order
  always_comb begin
    nx_we   = 1'b0;
    nx_addr = node_r;
    nx_data = LINK_NONE;
    pv_we   = 1'b0;
    pv_addr = node_r;
    pv_data = LINK_NONE;
    if (state_r == S_W1) begin
      unique case (kind_r)
        dll_pkg::KIND_PREPEND: begin
          nx_we = 1'b1; nx_addr = node_r; nx_data = head_r;
          pv_we = 1'b1; pv_addr = node_r; pv_data = LINK_NONE;
        end
        dll_pkg::KIND_APPEND: begin
          pv_we = 1'b1; pv_addr = node_r; pv_data = tail_r;
          nx_we = 1'b1; nx_addr = node_r; nx_data = LINK_NONE;
        end
        dll_pkg::KIND_BEFORE: begin
          pv_we = 1'b1;  pv_addr = node_r; pv_data = rp_r;
          nx_we = rp_ok; nx_addr = rp_r;   nx_data = node_r;
        end
        dll_pkg::KIND_AFTER: begin
          nx_we = 1'b1;  nx_addr = node_r; nx_data = rn_r;
          pv_we = rn_ok; pv_addr = rn_r;   pv_data = node_r;
        end
        dll_pkg::KIND_REMOVE: begin
          nx_we = rp_ok; nx_addr = rp_r; nx_data = rn_r;
          pv_we = rn_ok; pv_addr = rn_r; pv_data = rp_r;
        end
        default: begin
        end
      endcase
    end else if (state_r == S_W2) begin
      unique case (kind_r)
        dll_pkg::KIND_PREPEND: begin
          pv_we = head_ok; pv_addr = head_r; pv_data = node_r;
        end
        dll_pkg::KIND_APPEND: begin
          nx_we = tail_ok; nx_addr = tail_r; nx_data = node_r;
        end
        dll_pkg::KIND_BEFORE: begin
          pv_we = 1'b1; pv_addr = ref_r;  pv_data = node_r;
          nx_we = 1'b1; nx_addr = node_r; nx_data = ref_r;
        end
        dll_pkg::KIND_AFTER: begin
          nx_we = 1'b1; nx_addr = ref_r;  nx_data = node_r;
          pv_we = 1'b1; pv_addr = node_r; pv_data = ref_r;
        end
        default: begin
        end
      endcase
    end
  end

  // list registers and the item node's final links
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    total_nxt = total_r;
    nn        = LINK_NONE;
    np        = LINK_NONE;
    unique case (kind_r)
      dll_pkg::KIND_PREPEND: begin
        head_nxt  = node_r;
        tail_nxt  = head_ok ? tail_r : node_r;
        total_nxt = count_up;
        nn        = head_r;
        np        = (head_ok && head_r == node_r) ? node_r : LINK_NONE;
      end
      dll_pkg::KIND_APPEND: begin
        tail_nxt  = node_r;
        head_nxt  = tail_ok ? head_r : node_r;
        total_nxt = count_up;
        np        = tail_r;
        nn        = (tail_ok && tail_r == node_r) ? node_r : LINK_NONE;
      end
      dll_pkg::KIND_BEFORE: begin
        head_nxt  = rp_ok ? head_r : node_r;
        total_nxt = count_up;
        nn        = ref_r;
        np        = (ref_r == node_r) ? node_r : rp_r;
      end
      dll_pkg::KIND_AFTER: begin
        tail_nxt  = rn_ok ? tail_r : node_r;
        total_nxt = count_up;
        nn        = (ref_r == node_r) ? node_r : rn_r;
        np        = ref_r;
      end
      dll_pkg::KIND_REMOVE: begin
        head_nxt  = rp_ok ? head_r : rn_r;
        tail_nxt  = rn_ok ? tail_r : rp_r;
        total_nxt = count_down;
        nn        = rn_r;
        np        = rp_r;
      end
      dll_pkg::KIND_HOLD: begin
        nn = rn_r;
        np = rp_r;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= LINK_NONE;
      tail_r      <= LINK_NONE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == S_W2;
      if (state_r == S_W2) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        total_r <= total_nxt;
      end
    end
  end

  // command capture and result register
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= cmd.kind;
      node_r <= cmd_node;
      ref_r  <= cmd_ref;
    end
    if (state_r == S_W2) begin
      out_item_r.head_index <= 7'(head_nxt);
      out_item_r.tail_index <= 7'(tail_nxt);
      out_item_r.node_total <= 7'(total_nxt);
      out_item_r.node_next  <= 7'(nn);
      out_item_r.node_prev  <= 7'(np);
    end
  end

  // next link memory, registered read
  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[IDX_W'(nx_addr)] <= nx_data;
    end
    if (pop) begin
      rn_r <= next_mem[IDX_W'(rd_link)];
    end
  end

  // previous link memory, registered read
  always_ff @(posedge clk) begin
    if (pv_we) begin
      prev_mem[IDX_W'(pv_addr)] <= pv_data;
    end
    if (pop) begin
      rp_r <= prev_mem[IDX_W'(rd_link)];
    end
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;

endmodule

/* hw/rtl/doubly_linked_list_manager.sv */
// top level of the doubly linked list manager
//
//   channel   ports                     handshake
//   input     start, busy, in_item      beat taken when start && !busy
//   result    out_strobe, out_item      beat shown for one cycle, always taken
//
// in the back each beat takes one link read of both memories,
// then two write steps, since each link memory has a single write port
// the result appears in the cycle after the last write step; the back pops
// a new beat only once it is idle again, so beats never overlap in the back
// busy rises only when the two-entry command queue is full
// reset (synchronous, active low) empties the list; link memories are not cleared
// the receiver cannot stall, results are never held back
`timescale 1ns / 1ps

module doubly_linked_list_manager #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dll_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output dll_pkg::out_item_t out_item
);

  logic                  push;
  dll_pkg::cmd_t         front_cmd;
  dll_pkg::cmd_t         queue_cmd;
  dll_pkg::q_status_t    q_status;
  dll_pkg::back_status_t back_status;

  assign busy = q_status.full;

  // accept and classify
  dll_front #(
    .POOL_NODES(POOL_NODES)
  ) u_front (
    .start  (start),
    .busy   (busy),
    .in_item(in_item),
    .push   (push),
    .cmd    (front_cmd)
  );

  // command queue
  dll_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(front_cmd),
    .pop     (back_status.pop),
    .pop_cmd (queue_cmd),
    .status  (q_status)
  );

  // execute on the link memories
  dll_back #(
    .POOL_NODES(POOL_NODES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .cmd       (queue_cmd),
    .status    (back_status),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  // result strobes are never back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobes in back-to-back cycles");

  // a beat taken by an empty, idle block returns its result after the read and both write steps
  a_idle_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && q_status.empty && back_status.idle) |-> ##4 out_strobe)
    else $error("result missing after beat taken on idle block");

  // a pop only happens from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    back_status.pop |-> !q_status.empty)
    else $error("back popped an empty queue");

endmodule
